/* rtl/gppf_pkg.sv */
// Shared types, constants and codes of the GPT payload partition finder.
`default_nettype none
package gppf_pkg;

  // One input word: an image byte and the start-of-image mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  payload_slot;
    logic [63:0] first_lba;
    logic [63:0] last_lba;
  } out_word_t;

  // Status codes.
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_NO_MBR     = 4'd1;
  localparam logic [3:0] ST_NO_PROT    = 4'd2;
  localparam logic [3:0] ST_SIGNATURE  = 4'd3;
  localparam logic [3:0] ST_VERSION    = 4'd4;
  localparam logic [3:0] ST_HDR_SIZE   = 4'd5;
  localparam logic [3:0] ST_CUR_LBA    = 4'd6;
  localparam logic [3:0] ST_BACKUP_LBA = 4'd7;
  localparam logic [3:0] ST_PRIMARY    = 4'd8;
  localparam logic [3:0] ST_SECONDARY  = 4'd9;
  localparam logic [3:0] ST_TOO_MANY   = 4'd10;
  localparam logic [3:0] ST_NO_PAYLOAD = 4'd11;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLOCK_UNITS = 2'd0;
  localparam logic [1:0] CFG_DISK_BLOCKS = 2'd1;
  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

  // Header and entry constants.
  localparam logic [63:0] GPT_SIG = 64'h5452415020494645;
  localparam logic [63:0] GPT_REV = 64'h0000000000010000;
  localparam logic [63:0] GPT_HDR_SIZE = 64'd92;
  localparam logic [7:0]  MBR_PROT_TYPE = 8'hee;
  localparam logic [7:0]  MBR_SIG0 = 8'h55;
  localparam logic [7:0]  MBR_SIG1 = 8'haa;

  localparam logic [63:0] GUID_HEAD [3] = '{64'h46f68e5ee5ab07a0, 64'h4b6dc9205f04b556,
                                             64'h4b78d766c195cc59};
  localparam logic [63:0] GUID_TAIL [3] = '{64'h9ce841a518929b7c, 64'hbd77804efe6fae01,
                                             64'h813fa0e1519099d8};

  // Depth of the byte queue between front and back.
  localparam int QDEPTH = 4;

  // Parser sequencer states.
  typedef enum logic [1:0] {
    PS_RUN,
    PS_DIV,
    PS_CLIP
  } pstate_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [6:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_resp_t;

endpackage
`default_nettype wire

/* rtl/gppf_byte_queue.sv */
// Front queue that accepts input words and holds them for the parser.
`default_nettype none
module gppf_byte_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gppf_pkg::in_word_t in_word,
  output logic                   q_valid,
  output gppf_pkg::in_word_t     q_word,
  input  wire logic              q_take
);
  import gppf_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  in_word_t        mem [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            push;
  logic            pop;

  assign in_stall = (count == (PW+1)'(QDEPTH));
  assign q_valid  = (count != '0);
  assign q_word   = mem[rd_ptr];
  assign push     = in_valid && !in_stall;
  assign pop      = q_take && q_valid;

  // Storage for queued words.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_word;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

/* rtl/gppf_divider.sv */
// Restoring divider, one quotient bit per cycle, for the table size.
`default_nettype none
module gppf_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gppf_pkg::div_req_t req,
  output gppf_pkg::div_resp_t     resp
);
  import gppf_pkg::*;

  logic [31:0] n;
  logic [6:0]  r;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [7:0]  trial;
  logic        fits;

  assign trial = {r, n[31]};
  assign fits  = (trial >= {1'b0, req.den});
  assign resp.done = done;
  assign resp.quot = n;

  // Shift the dividend through the remainder one bit a cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      n <= req.num;
      r <= '0;
    end else if (busy) begin
      n <= {n[30:0], fits};
      r <= fits ? 7'(trial - {1'b0, req.den}) : trial[6:0];
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/gppf_parser.sv */
// Back end: decodes MBR, GPT header and entries and forms the result word.
`default_nettype none
module gppf_parser #(
  parameter int MAX_ENTRIES = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  input  wire gppf_pkg::in_word_t   byte_word,
  output logic                      byte_take,
  input  wire logic [6:0]           units,
  input  wire logic [47:0]          disk_blocks,
  input  wire logic [18:0]          max_payload,
  output gppf_pkg::div_req_t        div_req,
  input  wire gppf_pkg::div_resp_t  div_resp,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output gppf_pkg::out_word_t       out_word
);
  import gppf_pkg::*;

  localparam logic [23:0] POS_MAX = '1;

  pstate_t     state, state_next;
  logic [23:0] pos, pos_next;
  logic [63:0] fs, fs_next;
  logic        prot, prot_next;
  logic        mbr_bad, mbr_bad_next;
  logic [3:0]  herr, herr_next;
  logic [63:0] first_usable, first_usable_next;
  logic [63:0] last_usable, last_usable_next;
  logic [16:0] total, total_next;
  logic [16:0] num, num_next;
  logic        nz, nz_next;
  logic [63:0] thead, thead_next;
  logic [63:0] ttail, ttail_next;
  logic [63:0] slba, slba_next;
  logic [2:0]  mask, mask_next;
  logic        finished, finished_next;
  logic [63:0] slot_first [3];
  logic [63:0] slot_last [3];
  logic [2:0]  slot_wr;

  logic        out_free;
  logic        may_emit;
  logic        go;
  logic        emit_err;
  logic [3:0]  emit_code;
  logic        to_clip;
  logic        start_div;

  logic [7:0]  b;
  logic [6:0]  lo;
  logic        hdr_hit;
  logic [2:0]  k;
  logic [14:0] bs;
  logic [23:0] vpos;
  logic        ent_hit;

  logic [63:0] need;
  logic [63:0] disk64;
  logic [31:0] tab_num;

  logic [1:0]  sel;
  logic [63:0] cf, cl, lim, diff, clipped;

  // Only a byte that can reach the verdict has to wait for a free output register.
  assign out_free  = !out_valid || !out_stall;
  assign may_emit  = !byte_word.restart && !finished && (pos >= vpos);
  assign go        = (state == PS_RUN) && byte_valid && (out_free || !may_emit);
  assign byte_take = go;
  assign b         = byte_word.data_byte;
  assign bs        = {units, 8'd0} >> 1;
  assign vpos      = ({9'd0, bs} + 24'd91 > 24'd511) ? {9'd0, bs} + 24'd91 : 24'd511;
  assign disk64    = {16'd0, disk_blocks};
  assign tab_num   = fs[31:0];
  assign need      = 64'd2 + {32'd0, div_resp.quot};

  assign div_req.start = start_div;
  assign div_req.num   = fs_next[31:0];
  assign div_req.den   = units;

  // Little-endian field accumulation.
  function automatic logic [63:0] acc(input logic [63:0] cur, input logic [2:0] idx,
                                      input logic [7:0] v);
    logic [63:0] sh;
    sh = {56'd0, v} << {idx, 3'd0};
    return (idx == 3'd0) ? sh : (cur | sh);
  endfunction

  // Per-byte decode; restart clears the parse state before the byte is used.
  always_comb begin
    pos_next          = pos;
    fs_next           = fs;
    prot_next         = prot;
    mbr_bad_next      = mbr_bad;
    herr_next         = herr;
    first_usable_next = first_usable;
    last_usable_next  = last_usable;
    total_next        = total;
    num_next          = num;
    nz_next           = nz;
    thead_next        = thead;
    ttail_next        = ttail;
    slba_next         = slba;
    mask_next         = mask;
    finished_next     = finished;
    slot_wr           = '0;
    emit_err          = 1'b0;
    emit_code         = ST_OK;
    to_clip           = 1'b0;
    start_div         = 1'b0;
    lo                = pos[6:0];
    hdr_hit           = 1'b0;
    k                 = '0;
    ent_hit           = 1'b0;

    if (go) begin
      if (byte_word.restart) begin
        pos_next = '0; fs_next = '0; prot_next = 1'b0; mbr_bad_next = 1'b0;
        herr_next = '0; first_usable_next = '0; last_usable_next = '0;
        total_next = '0; num_next = '0; nz_next = 1'b0; thead_next = '0;
        ttail_next = '0; slba_next = '0; mask_next = '0; finished_next = 1'b0;
      end
      lo = pos_next[6:0];
      if (!finished_next) begin
        // MBR signature and protective entry.
        if (pos_next == 24'd510 && b != MBR_SIG0) mbr_bad_next = 1'b1;
        if (pos_next == 24'd511 && b != MBR_SIG1) mbr_bad_next = 1'b1;
        if ((pos_next == 24'd450 || pos_next == 24'd466 || pos_next == 24'd482 ||
             pos_next == 24'd498) && b == MBR_PROT_TYPE) prot_next = 1'b1;

        // Header at LBA 1: the byte offset is the low seven bits.
        hdr_hit = (pos_next[23:7] == {10'd0, units}) && (lo < 7'd92);
        k = (lo >= 7'd12 && lo < 7'd16) ? {1'b0, lo[1:0]} : lo[2:0];
        if (hdr_hit) begin
          if (lo < 7'd16 || (lo >= 7'd24 && lo < 7'd56) || (lo >= 7'd80 && lo < 7'd84)) begin
            fs_next = acc(fs_next, k, b);
          end
          if (lo == 7'd7 && fs_next != GPT_SIG && herr_next == '0) herr_next = ST_SIGNATURE;
          if (lo == 7'd11 && fs_next != GPT_REV && herr_next == '0) herr_next = ST_VERSION;
          if (lo == 7'd15 && fs_next != GPT_HDR_SIZE && herr_next == '0)
            herr_next = ST_HDR_SIZE;
          if (lo == 7'd31 && fs_next != 64'd1 && herr_next == '0) herr_next = ST_CUR_LBA;
          if (lo == 7'd39 && fs_next != disk64 - 64'd1 && herr_next == '0)
            herr_next = ST_BACKUP_LBA;
          if (lo == 7'd47) first_usable_next = fs_next;
          if (lo == 7'd55) last_usable_next = fs_next;
          if (lo == 7'd83) start_div = 1'b1;
        end

        // Entry table from LBA 2, 128 bytes per entry.
        ent_hit = (pos_next >= {9'd0, units, 8'd0}) && (herr_next == '0) &&
                  (num_next < total_next);
        if (ent_hit) begin
          if (lo == 7'd0) begin
            thead_next = '0; ttail_next = '0; nz_next = 1'b0; slba_next = '0;
          end
          if (lo < 7'd8) begin
            thead_next = thead_next | ({56'd0, b} << {lo[2:0], 3'd0});
          end else if (lo < 7'd16) begin
            ttail_next = {ttail_next[55:0], b};
          end else if (lo >= 7'd32 && lo < 7'd40) begin
            slba_next = slba_next | ({56'd0, b} << {lo[2:0], 3'd0});
          end else if (lo >= 7'd40 && lo < 7'd48) begin
            fs_next = acc(fs_next, lo[2:0], b);
            if (lo == 7'd47 && nz_next) begin
              for (int i = 0; i < 3; i++) begin
                if (thead_next == GUID_HEAD[i] && ttail_next == GUID_TAIL[i] &&
                    !mask_next[i]) begin
                  slot_wr[i] = 1'b1;
                  if (slba_next <= fs_next && fs_next <= last_usable_next)
                    mask_next[i] = 1'b1;
                end
              end
            end
          end
          if (lo < 7'd16 && b != 8'd0) nz_next = 1'b1;
          if (lo == 7'd127) num_next = num_next + 1'b1;
        end

        // Verdict once the header has been seen.
        if (pos_next >= vpos) begin
          if (mbr_bad_next) begin
            emit_err = 1'b1; emit_code = ST_NO_MBR; finished_next = 1'b1;
          end else if (!prot_next) begin
            emit_err = 1'b1; emit_code = ST_NO_PROT; finished_next = 1'b1;
          end else if (herr_next != '0) begin
            emit_err = 1'b1; emit_code = herr_next; finished_next = 1'b1;
          end else if (num_next >= total_next) begin
            to_clip = 1'b1; finished_next = 1'b1;
          end
        end
        if (pos_next < POS_MAX) pos_next = pos_next + 1'b1;
      end
    end else if (state == PS_DIV && div_resp.done) begin
      // Table space checks once the table size is known.
      if (first_usable < need) begin
        if (herr_next == '0) herr_next = ST_PRIMARY;
      end else if (disk64 < need || last_usable > disk64 - need) begin
        if (herr_next == '0) herr_next = ST_SECONDARY;
      end else if ({32'd0, tab_num} > 64'(MAX_ENTRIES)) begin
        if (herr_next == '0) herr_next = ST_TOO_MANY;
      end
      if (herr_next == '0) total_next = tab_num[16:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      PS_RUN: begin
        if (start_div) state_next = PS_DIV;
        else if (to_clip) state_next = PS_CLIP;
      end
      PS_DIV: begin
        if (div_resp.done) state_next = PS_RUN;
      end
      PS_CLIP: begin
        if (out_free) state_next = PS_RUN;
      end
      default: state_next = PS_RUN;
    endcase
  end

  // Slot choice and clipping of the chosen range.
  always_comb begin
    priority if (mask == 3'd2 || mask == 3'd6) sel = 2'd1;
    else if (mask == 3'd4 || mask == 3'd5) sel = 2'd2;
    else sel = 2'd0;
    cf      = slot_first[sel];
    cl      = slot_last[sel];
    lim     = (max_payload == '0) ? 64'd1 : {45'd0, max_payload};
    diff    = cl - cf;
    clipped = (diff >= lim) ? cf + lim - 64'd1 : cl;
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PS_RUN; pos <= '0; fs <= '0; prot <= 1'b0; mbr_bad <= 1'b0;
      herr <= '0; first_usable <= '0; last_usable <= '0; total <= '0; num <= '0;
      nz <= 1'b0; thead <= '0; ttail <= '0; slba <= '0; mask <= '0;
      finished <= 1'b0;
    end else begin
      state <= state_next; pos <= pos_next; fs <= fs_next; prot <= prot_next;
      mbr_bad <= mbr_bad_next; herr <= herr_next; first_usable <= first_usable_next;
      last_usable <= last_usable_next; total <= total_next; num <= num_next;
      nz <= nz_next; thead <= thead_next; ttail <= ttail_next; slba <= slba_next;
      mask <= mask_next; finished <= finished_next;
    end
  end

  // Slot range stores.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (slot_wr[i]) begin
        slot_first[i] <= slba_next;
        slot_last[i]  <= fs_next;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit_err || (state == PS_CLIP);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == PS_CLIP) begin
        if (mask == '0) begin
          out_word <= '{status: ST_NO_PAYLOAD, payload_slot: 2'd0, first_lba: '0,
                        last_lba: '0};
        end else begin
          out_word <= '{status: ST_OK, payload_slot: sel, first_lba: cf, last_lba: clipped};
        end
      end else if (emit_err) begin
        out_word <= '{status: emit_code, payload_slot: 2'd0, first_lba: '0, last_lba: '0};
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/gpt_payload_partition_finder.sv */
// Top level of the GPT payload partition finder: configuration, queue, parser, divider.
`default_nettype none
// Takes a disk image one byte per word from LBA 0 and returns at most one result word
// per image: a status, the chosen payload slot and its clipped block range. Bytes are
// taken at one per cycle between pauses. The parser pauses at header byte 83, where
// the entry table size is divided by the sector size in a bit-serial divider, while
// the four-word input queue keeps filling. The final result waits in a clip state for
// slot selection and clipping, during which no byte is taken. While a result word is
// held by the receiver, only a byte that could give the next verdict has to wait.
module gpt_payload_partition_finder #(
  parameter int MAX_ENTRIES = 65536,
  parameter int MAX_BLOCK_BYTES = 8192
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire gppf_pkg::in_word_t in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gppf_pkg::out_word_t     out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [47:0]        cfg_data
);
  import gppf_pkg::*;

  localparam logic [6:0] MAX_UNITS = 7'(MAX_BLOCK_BYTES / 128);

  logic [6:0]  units_reg;
  logic [47:0] disk_blocks;
  logic [18:0] max_payload;
  logic [6:0]  units_eff;
  logic        q_valid;
  in_word_t    q_word;
  logic        q_take;
  div_req_t    div_req;
  div_resp_t   div_resp;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      units_reg   <= 7'd4;
      disk_blocks <= '0;
      max_payload <= 19'd122880;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLOCK_UNITS: units_reg <= cfg_data[6:0];
        CFG_DISK_BLOCKS: disk_blocks <= cfg_data;
        CFG_MAX_PAYLOAD: max_payload <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  // Sector size clamped to the supported range.
  always_comb begin
    priority if (units_reg == '0) units_eff = 7'd1;
    else if (units_reg > MAX_UNITS) units_eff = MAX_UNITS;
    else units_eff = units_reg;
  end

  gppf_byte_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .q_valid(q_valid), .q_word(q_word), .q_take(q_take)
  );

  gppf_parser #(.MAX_ENTRIES(MAX_ENTRIES)) u_parser (
    .clk(clk), .rst(rst), .byte_valid(q_valid), .byte_word(q_word), .byte_take(q_take),
    .units(units_eff), .disk_blocks(disk_blocks), .max_payload(max_payload),
    .div_req(div_req), .div_resp(div_resp), .out_valid(out_valid),
    .out_stall(out_stall), .out_word(out_word)
  );

  gppf_divider u_div (
    .clk(clk), .rst(rst), .req(div_req), .resp(div_resp)
  );
endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the GPT payload partition finder.
`default_nettype none
module tb;
  import gppf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned POS_TOP = 24'hFFFFFF;
  localparam int unsigned ENTRY_CAP = 65536;

  // Kinds of partition entry that the image builder can place.
  typedef enum int {PK_A, PK_B, PK_C, PK_EMPTY, PK_UNKNOWN} part_kind_t;
  // Ways in which an image can be damaged on purpose.
  typedef enum int {
    DMG_NONE, DMG_MBR, DMG_PROT, DMG_SIG, DMG_REV, DMG_SIZE, DMG_CUR,
    DMG_BACKUP, DMG_PRIMARY, DMG_SECOND, DMG_MANY, DMG_NOISE
  } damage_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_BLOCK_UNITS;
  logic [47:0] cfg_data = '0;

  gpt_payload_partition_finder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Configuration as the predictor sees it.
  logic [6:0]  units_reg = 7'd4;
  logic [47:0] disk_reg = '0;
  logic [18:0] limit_reg = 19'd122880;

  // Parser state of the predictor.
  int unsigned pos, hdr_err, ent_total, ent_idx;
  logic [63:0] shreg, use_first, use_last, type_lo, type_hi, ent_start;
  bit          prot_seen, mbr_fail, ent_nz, img_done;
  logic [2:0]  taken;
  logic [63:0] slot_lo [3];
  logic [63:0] slot_hi [3];

  out_word_t   verdicts_due [$];
  int unsigned fails = 0, words_sent = 0, results_seen = 0, images = 0;
  bit [15:0]   status_seen = '0;
  int unsigned cycles = 0;

  // Parts of the next image, offsets counted from the first usable block.
  part_kind_t  part_kind [$];
  logic [63:0] part_lo [$];
  logic [63:0] part_hi [$];

  // Sender burst shaping.
  int unsigned burst_left = 0;
  bit          steady = 1'b0;

  function automatic int unsigned eff_units();
    int unsigned u;
    u = units_reg;
    if (u < 1) u = 1;
    if (u > 64) u = 64;
    return u;
  endfunction

  function automatic void clear_parse();
    pos = 0; shreg = '0; prot_seen = 0; mbr_fail = 0; ent_nz = 0; img_done = 0;
    hdr_err = 0; use_first = '0; use_last = '0; ent_total = 0; ent_idx = 0;
    taken = '0; type_lo = '0; type_hi = '0; ent_start = '0;
    for (int i = 0; i < 3; i++) begin
      slot_lo[i] = '0;
      slot_hi[i] = '0;
    end
  endfunction

  // Little-endian field assembly shared by header and entry fields.
  function automatic void shift_in(int unsigned k, logic [7:0] b);
    logic [63:0] v;
    v = 64'(b) << (8 * (k % 8));
    shreg = (k == 0) ? v : (shreg | v);
  endfunction

  function automatic void flag_header(int unsigned code);
    if (hdr_err == 0) hdr_err = code;
  endfunction

  function automatic void header_byte(int unsigned h, logic [7:0] b);
    logic [63:0] need, disk64;
    disk64 = 64'(disk_reg);
    if (h < 8) begin
      shift_in(h, b);
      if (h == 7 && shreg != GPT_SIG) flag_header(ST_SIGNATURE);
    end else if (h < 12) begin
      shift_in(h - 8, b);
      if (h == 11 && shreg != GPT_REV) flag_header(ST_VERSION);
    end else if (h < 16) begin
      shift_in(h - 12, b);
      if (h == 15 && shreg != 64'd92) flag_header(ST_HDR_SIZE);
    end else if (h >= 24 && h < 32) begin
      shift_in(h - 24, b);
      if (h == 31 && shreg != 64'd1) flag_header(ST_CUR_LBA);
    end else if (h >= 32 && h < 40) begin
      shift_in(h - 32, b);
      if (h == 39 && shreg != disk64 - 64'd1) flag_header(ST_BACKUP_LBA);
    end else if (h >= 40 && h < 48) begin
      shift_in(h - 40, b);
      if (h == 47) use_first = shreg;
    end else if (h >= 48 && h < 56) begin
      shift_in(h - 48, b);
      if (h == 55) use_last = shreg;
    end else if (h >= 80 && h < 84) begin
      shift_in(h - 80, b);
      if (h == 83) begin
        // Table size truncates; both space checks use it.
        need = 64'd2 + shreg / 64'(eff_units());
        if (use_first < need) flag_header(ST_PRIMARY);
        else if (disk64 < need || use_last > disk64 - need) flag_header(ST_SECONDARY);
        else if (shreg > 64'(ENTRY_CAP)) flag_header(ST_TOO_MANY);
        if (hdr_err == 0) ent_total = shreg[31:0];
      end
    end
  endfunction

  function automatic void entry_byte(int unsigned o, logic [7:0] b);
    if (o == 0) begin
      type_lo = '0; type_hi = '0; ent_nz = 0; ent_start = '0;
    end
    if (o < 8) type_lo |= 64'(b) << (8 * o);
    else if (o < 16) type_hi = {type_hi[55:0], b};
    else if (o >= 32 && o < 40) ent_start |= 64'(b) << (8 * (o - 32));
    else if (o >= 40 && o < 48) begin
      shift_in(o - 40, b);
      // A bogus range is stored but leaves the slot free for a later entry.
      if (o == 47 && ent_nz) begin
        for (int i = 0; i < 3; i++) begin
          if (type_lo == GUID_HEAD[i] && type_hi == GUID_TAIL[i] && !taken[i]) begin
            slot_lo[i] = ent_start;
            slot_hi[i] = shreg;
            if (ent_start <= shreg && shreg <= use_last) taken[i] = 1'b1;
          end
        end
      end
    end
    if (o < 16 && b != 0) ent_nz = 1;
    if (o == 127) ent_idx++;
  endfunction

  function automatic out_word_t pick_payload();
    out_word_t w;
    int unsigned s;
    logic [63:0] lim;
    w = '0;
    if (taken == 3'b000) begin
      w.status = ST_NO_PAYLOAD;
      return w;
    end
    s = 0;
    if (taken == 3'b010 || taken == 3'b110) s = 1;
    if (taken == 3'b100 || taken == 3'b101) s = 2;
    lim = (limit_reg == 0) ? 64'd1 : 64'(limit_reg);
    w.status = ST_OK;
    w.payload_slot = 2'(s);
    w.first_lba = slot_lo[s];
    w.last_lba = (slot_hi[s] - slot_lo[s] >= lim) ? slot_lo[s] + lim - 64'd1 : slot_hi[s];
    return w;
  endfunction

  // Advances the predictor by one accepted word and queues any verdict.
  function automatic void predict_word(logic [7:0] b, bit r);
    int unsigned p, bs, gate;
    out_word_t w;
    bit hit;
    if (r) clear_parse();
    if (img_done) return;
    p = pos;
    bs = eff_units() * 128;
    hit = 0;
    w = '0;
    if (p == 510 && b != MBR_SIG0) mbr_fail = 1;
    if (p == 511 && b != MBR_SIG1) mbr_fail = 1;
    if ((p == 450 || p == 466 || p == 482 || p == 498) && b == MBR_PROT_TYPE)
      prot_seen = 1;
    if (p >= bs && p < bs + 92) header_byte(p - bs, b);
    if (p >= 2 * bs && hdr_err == 0 && ent_idx < ent_total)
      entry_byte((p - 2 * bs) % 128, b);
    gate = (bs + 91 > 511) ? bs + 91 : 511;
    if (p >= gate) begin
      hit = 1;
      if (mbr_fail) w.status = ST_NO_MBR;
      else if (!prot_seen) w.status = ST_NO_PROT;
      else if (hdr_err != 0) w.status = 4'(hdr_err);
      else if (ent_idx >= ent_total) w = pick_payload();
      else hit = 0;
    end
    if (hit) begin
      img_done = 1;
      verdicts_due.push_back(w);
    end
    if (pos < POS_TOP) pos++;
  endfunction

  // Sends one word, then maybe pauses to close the current burst.
  task automatic send_word(input logic [7:0] b, input bit r);
    int unsigned gap;
    in_valid <= 1'b1;
    in_word <= '{data_byte: b, restart: r};
    do @(posedge clk); while (in_stall);
    predict_word(b, r);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) steady = !steady;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Waits until every verdict has come, then lets the divider and queue settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BLOCK_UNITS: units_reg = val[6:0];
      CFG_DISK_BLOCKS: disk_reg = val;
      CFG_MAX_PAYLOAD: limit_reg = val[18:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [6:0] u, input logic [47:0] d, input logic [18:0] m);
    drain();
    write_reg(CFG_BLOCK_UNITS, 48'(u));
    write_reg(CFG_DISK_BLOCKS, d);
    write_reg(CFG_MAX_PAYLOAD, 48'(m));
  endtask

  task automatic put_le(ref logic [7:0] a [], input int unsigned at, input logic [63:0] v,
                        input int unsigned n);
    for (int unsigned k = 0; k < n; k++) a[at + k] = v[8 * k +: 8];
  endtask

  function automatic void add_part(part_kind_t k, logic [63:0] lo, logic [63:0] hi);
    part_kind.push_back(k);
    part_lo.push_back(lo);
    part_hi.push_back(hi);
  endfunction

  // Builds one image from the queued parts and streams it; cut drops its tail.
  task automatic play_image(input damage_t dmg, input bit cut);
    int unsigned u, bs, nent, len, at;
    logic [63:0] need, fu, lu, num, d64, head, tail;
    logic [7:0] img [];
    u = eff_units();
    bs = u * 128;
    nent = part_kind.size();
    d64 = 64'(disk_reg);
    num = (dmg == DMG_MANY) ? 64'(ENTRY_CAP + $urandom_range(1, 3000)) : 64'(nent);
    need = 64'd2 + num / 64'(u);
    fu = need + 64'($urandom_range(0, 2));
    lu = (d64 >= 2 * need + 4) ? d64 - need - 64'($urandom_range(0, 2)) : fu;
    if (dmg == DMG_PRIMARY) fu = need - 64'd1;
    if (dmg == DMG_SECOND) lu = d64 - need + 64'($urandom_range(1, 5));
    len = 2 * bs + 128 * nent;
    if (len < 512) len = 512;
    img = new[len];
    foreach (img[i]) img[i] = (dmg == DMG_NOISE) ? 8'($urandom) : 8'h00;
    if (dmg != DMG_NOISE) begin
      for (int unsigned i = 0; i < nent; i++) begin
        at = 2 * bs + 128 * i;
        for (int unsigned k = 16; k < 128; k++) img[at + k] = 8'($urandom);
        case (part_kind[i])
          PK_A, PK_B, PK_C: begin
            head = GUID_HEAD[int'(part_kind[i])];
            tail = GUID_TAIL[int'(part_kind[i])];
          end
          PK_EMPTY: begin
            head = '0;
            tail = '0;
          end
          default: begin
            head = {$urandom, $urandom};
            tail = {$urandom, $urandom};
          end
        endcase
        put_le(img, at, head, 8);
        for (int unsigned k = 0; k < 8; k++) img[at + 8 + k] = tail[63 - 8 * k -: 8];
        put_le(img, at + 32, fu + part_lo[i], 8);
        put_le(img, at + 40, fu + part_hi[i], 8);
      end
      // Header at LBA 1, each field bent only by its own damage kind.
      put_le(img, bs, (dmg == DMG_SIG) ? GPT_SIG ^ (64'd1 << $urandom_range(0, 63)) : GPT_SIG, 8);
      put_le(img, bs + 8, (dmg == DMG_REV) ? GPT_REV ^ (64'd1 << $urandom_range(0, 31)) : GPT_REV, 4);
      put_le(img, bs + 12, (dmg == DMG_SIZE) ? 64'd93 + $urandom_range(0, 9) : 64'd92, 4);
      put_le(img, bs + 16, {$urandom, $urandom}, 8);
      put_le(img, bs + 24, (dmg == DMG_CUR) ? 64'd2 + $urandom_range(0, 9) : 64'd1, 8);
      put_le(img, bs + 32, (dmg == DMG_BACKUP) ? d64 + $urandom_range(0, 9) : d64 - 64'd1, 8);
      put_le(img, bs + 40, fu, 8);
      put_le(img, bs + 48, lu, 8);
      put_le(img, bs + 56, {$urandom, $urandom}, 8);
      put_le(img, bs + 64, {$urandom, $urandom}, 8);
      put_le(img, bs + 72, {$urandom, $urandom}, 8);
      put_le(img, bs + 80, num, 4);
      put_le(img, bs + 84, {$urandom, $urandom}, 8);
      // The MBR goes in last, so it wins where small sectors overlap it.
      for (int unsigned k = 0; k < 4; k++)
        if (dmg == DMG_PROT || img[450 + 16 * k] == MBR_PROT_TYPE)
          img[450 + 16 * k] = 8'h83;
      if (dmg != DMG_PROT) img[450 + 16 * $urandom_range(0, 3)] = MBR_PROT_TYPE;
      img[510] = MBR_SIG0;
      img[511] = MBR_SIG1;
      if (dmg == DMG_MBR) img[510 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    if (cut) len = $urandom_range(1, len - 1);
    for (int unsigned i = 0; i < len; i++) send_word(img[i], i == 0);
    // Bytes after the verdict are ignored until the next restart.
    repeat ($urandom_range(0, 3)) send_word(8'($urandom), 1'b0);
    images++;
    part_kind.delete();
    part_lo.delete();
    part_hi.delete();
  endtask

  // Result check and receiver stall pattern.
  int unsigned stall_mode = 0, stall_tick = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("result word with nothing expected: status %0d", out_word.status);
          fails++;
        end else begin
          automatic out_word_t w = verdicts_due.pop_front();
          results_seen++;
          status_seen[w.status] = 1'b1;
          if (out_word.status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, out_word.status);
            fails++;
          end
          if (out_word.payload_slot !== w.payload_slot) begin
            $error("payload_slot: expected %0d, got %0d", w.payload_slot, out_word.payload_slot);
            fails++;
          end
          if (out_word.first_lba !== w.first_lba) begin
            $error("first_lba: expected %0h, got %0h", w.first_lba, out_word.first_lba);
            fails++;
          end
          if (out_word.last_lba !== w.last_lba) begin
            $error("last_lba: expected %0h, got %0h", w.last_lba, out_word.last_lba);
            fails++;
          end
        end
      end
      stall_tick++;
      if (stall_tick % 700 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= (stall_tick % 5 < 3);
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Every status code but ST_TOO_MANY, starting from the reset configuration.
  task automatic test_status_codes();
    add_part(PK_A, 0, 3);
    play_image(DMG_NONE, 0);
    set_config(7'd1, 48'd5000, 19'd100);
    for (int d = DMG_NONE; d <= DMG_NOISE; d++) begin
      add_part(PK_A, 0, 3);
      add_part(PK_B, 4, 9);
      play_image(damage_t'(d), 0);
    end
    play_image(DMG_NONE, 0);
    add_part(PK_A, 0, 3);
    play_image(DMG_NONE, 1);
  endtask

  // Slot selection, filtering and clipping.
  task automatic test_slot_rules();
    set_config(7'd2, 48'd20000, 19'd5);
    for (int m = 1; m < 8; m++) begin
      for (int k = 0; k < 3; k++)
        if (m[k]) add_part(part_kind_t'(k), 64'(10 * k), 64'(10 * k + 2 + m));
      play_image(DMG_NONE, 0);
    end
    add_part(PK_EMPTY, 0, 1);
    add_part(PK_UNKNOWN, 0, 1);
    add_part(PK_A, 7, 2);
    add_part(PK_A, 0, 64'hFFFF_FFFF_FFFF);
    add_part(PK_A, 1, 400);
    add_part(PK_A, 5, 6);
    play_image(DMG_NONE, 0);
    set_config(7'd3, 48'd30000, 19'd0);
    add_part(PK_C, 2, 50);
    play_image(DMG_NONE, 0);
  endtask

  // Sector sizes at and beyond both ends of the range.
  task automatic test_sector_sizes();
    logic [6:0] sizes [5] = '{7'd0, 7'd127, 7'd64, 7'd5, 7'd8};
    foreach (sizes[i]) begin
      set_config(sizes[i], 48'd900000, 19'd491520);
      add_part(PK_B, 0, 1000);
      add_part(PK_C, 3, 700000);
      play_image(DMG_NONE, 0);
    end
    set_config(7'd1, 48'hFFFF_FFFF_FFFF, 19'h7FFFF);
    add_part(PK_A, 0, 64'h0FFF_FFFF);
    play_image(DMG_NONE, 0);
    add_part(PK_A, 0, 9);
    play_image(DMG_MANY, 0);
  endtask

  // Random configurations, each with a run of mostly well-formed images.
  task automatic test_random();
    logic [6:0]  u;
    logic [47:0] d;
    logic [18:0] m;
    damage_t     dmg;
    int unsigned r;
    while (results_seen < 120) begin
      r = $urandom_range(0, 19);
      u = (r < 14) ? 7'($urandom_range(1, 4)) : (r < 18) ? 7'($urandom_range(0, 12))
        : (r == 18) ? 7'($urandom_range(65, 127)) : 7'd40;
      r = $urandom_range(0, 9);
      d = (r == 0) ? 48'd0 : (r == 1) ? 48'hFFFF_FFFF_FFFF : 48'($urandom_range(200, 2000000));
      r = $urandom_range(0, 9);
      m = (r == 0) ? 19'd0 : (r == 1) ? 19'd491520 : (r == 2) ? 19'h7FFFF
        : 19'($urandom_range(1, 300));
      set_config(u, d, m);
      repeat ($urandom_range(3, 7)) begin
        repeat ($urandom_range(0, 6)) begin
          r = $urandom_range(0, 9);
          if (r < 7) add_part(part_kind_t'($urandom_range(0, 2)), 64'($urandom_range(0, 60)),
                              64'($urandom_range(60, 900)));
          else if (r == 7) add_part(part_kind_t'($urandom_range(0, 4)),
                                    64'($urandom_range(50, 90)), 64'($urandom_range(0, 49)));
          else add_part(part_kind_t'($urandom_range(3, 4)), 0, 1);
        end
        r = $urandom_range(0, 19);
        dmg = (r < 13) ? DMG_NONE : damage_t'($urandom_range(DMG_MBR, DMG_NOISE));
        play_image(dmg, $urandom_range(0, 11) == 0);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    clear_parse();
    test_status_codes();
    test_slot_rules();
    test_sector_sizes();
    test_random();
    drain();
    $display("Streamed %0d images (%0d words); checked %0d results.",
             images, words_sent, results_seen);
    $display("Status codes observed (bit per code): %b", status_seen);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/gppf_pkg.sv
rtl/gppf_byte_queue.sv
rtl/gppf_divider.sv
rtl/gppf_parser.sv
rtl/gpt_payload_partition_finder.sv
verif/tb.sv
